FILE: hw/rtl/tpd_pkg.sv
package tpd_pkg;

   localparam int MaxPacketBytes = 4096;
   localparam int CountWidth     = $clog2(MaxPacketBytes + 1);
   localparam int LengthWidth    = 13;
   localparam int TagBytes       = 4;
   localparam int DataTailBytes  = 4;
   localparam int ButtonTailBytes = 2;
   localparam logic [7:0] LineEnd = 8'h0A;

   localparam int RegCount     = 7;
   localparam int CsrAddrWidth = $clog2(RegCount) + 2;
   localparam int RspDataWidth = 24;

   typedef enum logic [2:0] {
      KIND_COMMAND = 3'd0,
      KIND_DATA    = 3'd1,
      KIND_BUTTON  = 3'd2,
      KIND_LOG     = 3'd3,
      KIND_UNKNOWN = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_LEN_ERR  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      PHASE_HUNT   = 1'b0,
      PHASE_TAGGED = 1'b1
   } phase_type;

   typedef enum logic [2:0] {
      REG_TAG_COMMAND     = 3'd0,
      REG_TAG_DATA        = 3'd1,
      REG_TAG_BUTTON      = 3'd2,
      REG_TAG_LOG         = 3'd3,
      REG_TAIL_DATA       = 3'd4,
      REG_TAIL_BUTTON     = 3'd5,
      REG_EXPECTED_LENGTH = 3'd6
   } reg_index_type;

   typedef struct packed {
      status_type             status;
      logic [LengthWidth-1:0] length;
      kind_type               kind;
   } result_type;

endpackage

FILE: hw/rtl/tagged_packet_deframer.sv
// A packet's result is registered in the result register, or in the skid word while rsp stalls.
// Throughput: one byte per cycle while req_tready is high; the tag window compare and the byte counter update
// sit in a single stage between the framing state registers and the result register.
// A two-word output buffer (result register plus skid) absorbs one result while rsp stalls;
// req_tready drops only while the skid word is held.
// Reset (synchronous, active high) clears the framing state and the output buffer and
// loads the register defaults.
module tagged_packet_deframer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] rx_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [2:0] packet_kind, [15:3] packet_length, [17:16] packet_status, [23:18] zero
   output logic [tpd_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tpd_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import tpd_pkg::*;

   // configuration registers
   logic [31:0]            tag_command_ff, tag_data_ff, tag_button_ff, tag_log_ff;
   logic [31:0]            tail_data_ff;
   logic [15:0]            tail_button_ff;
   logic [LengthWidth-1:0] expected_len_ff;
   reg_index_type          csr_index;
   logic                   csr_write;

   // framing state
   logic [31:0]           recent_ff, recent_in;
   phase_type             phase_ff, phase_in;
   kind_type              kind_ff, kind_in;
   logic [CountWidth-1:0] count_ff, count_in;

   // output buffer
   logic       out_valid_ff, skid_valid_ff;
   result_type out_data_ff, skid_data_ff;

   logic                  accept;
   logic [31:0]           window;
   logic [CountWidth-1:0] count_inc;
   kind_type              tag_kind;
   logic                  emit;
   result_type            result;
   logic                  done;
   status_type            done_status;
   logic                  out_free;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_command_ff  <= 32'h5F4D4F43;
         tag_data_ff     <= '0;
         tag_button_ff   <= '0;
         tag_log_ff      <= '0;
         tail_data_ff    <= 32'h5A5A5A5A;
         tail_button_ff  <= 16'h5A5A;
         expected_len_ff <= LengthWidth'(64);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TAG_COMMAND:     tag_command_ff  <= csr_pwdata;
            REG_TAG_DATA:        tag_data_ff     <= csr_pwdata;
            REG_TAG_BUTTON:      tag_button_ff   <= csr_pwdata;
            REG_TAG_LOG:         tag_log_ff      <= csr_pwdata;
            REG_TAIL_DATA:       tail_data_ff    <= csr_pwdata;
            REG_TAIL_BUTTON:     tail_button_ff  <= csr_pwdata[15:0];
            REG_EXPECTED_LENGTH: expected_len_ff <= csr_pwdata[LengthWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TAG_COMMAND:     csr_prdata = tag_command_ff;
         REG_TAG_DATA:        csr_prdata = tag_data_ff;
         REG_TAG_BUTTON:      csr_prdata = tag_button_ff;
         REG_TAG_LOG:         csr_prdata = tag_log_ff;
         REG_TAIL_DATA:       csr_prdata = tail_data_ff;
         REG_TAIL_BUTTON:     csr_prdata = {16'd0, tail_button_ff};
         REG_EXPECTED_LENGTH: csr_prdata = {{(32 - LengthWidth){1'b0}}, expected_len_ff};
         default:             csr_prdata = '0;
      endcase
   end

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign window    = {req_tdata, recent_ff[31:8]};
   assign count_inc = (count_ff < CountWidth'(MaxPacketBytes)) ? count_ff + 1'b1 : count_ff;

   // first match wins: command, data, button, log
   always_comb begin
      if (window == tag_command_ff) tag_kind = KIND_COMMAND;
      else if (window == tag_data_ff) tag_kind = KIND_DATA;
      else if (window == tag_button_ff) tag_kind = KIND_BUTTON;
      else if (window == tag_log_ff) tag_kind = KIND_LOG;
      else tag_kind = KIND_UNKNOWN;
   end

   always_comb begin
      done        = 1'b0;
      done_status = STATUS_OK;
      case (kind_ff)
         KIND_COMMAND, KIND_LOG: begin
            done = (count_inc > CountWidth'(TagBytes)) && (req_tdata == LineEnd);
         end
         KIND_DATA: begin
            done = (count_inc >= CountWidth'(TagBytes + DataTailBytes))
                   && (window == tail_data_ff);
            if (LengthWidth'(count_inc) != expected_len_ff ||
                count_inc > CountWidth'(MaxPacketBytes)) begin
               done_status = STATUS_LEN_ERR;
            end
            if (count_inc != CountWidth'(LengthWidth'(count_inc))) begin
               done_status = STATUS_LEN_ERR;
            end
         end
         KIND_BUTTON: begin
            done = (count_inc >= CountWidth'(TagBytes + ButtonTailBytes))
                   && (window[31:16] == tail_button_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      recent_in     = window;
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      count_in      = count_inc;
      emit          = 1'b0;
      result.kind   = kind_ff;
      result.length = LengthWidth'(count_inc);
      result.status = STATUS_OK;
      unique case (phase_ff)
         PHASE_HUNT: begin
            if (count_inc >= CountWidth'(TagBytes) && tag_kind != KIND_UNKNOWN) begin
               // close any unknown bytes before the tag, open the tagged packet
               phase_in      = PHASE_TAGGED;
               kind_in       = tag_kind;
               count_in      = CountWidth'(TagBytes);
               emit          = (count_inc != CountWidth'(TagBytes));
               result.kind   = KIND_UNKNOWN;
               result.length = LengthWidth'(count_inc - CountWidth'(TagBytes));
            end else if (count_inc >= CountWidth'(MaxPacketBytes)) begin
               emit          = 1'b1;
               result.kind   = KIND_UNKNOWN;
               result.status = STATUS_OVERFLOW;
            end
         end
         PHASE_TAGGED: begin
            if (done) begin
               emit          = 1'b1;
               result.status = done_status;
            end else if (count_inc >= CountWidth'(MaxPacketBytes)) begin
               emit          = 1'b1;
               result.status = STATUS_OVERFLOW;
            end
         end
         default: ;
      endcase
      // drop the window and hunt afresh after a packet closes
      if (emit && phase_in == phase_ff) begin
         recent_in = '0;
         phase_in  = PHASE_HUNT;
         kind_in   = KIND_UNKNOWN;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         phase_ff  <= PHASE_HUNT;
         kind_ff   <= KIND_UNKNOWN;
         count_ff  <= '0;
      end else if (accept) begin
         recent_ff <= recent_in;
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         count_ff  <= count_in;
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept && emit;
         end
      end else if (accept && emit) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : result;
      end
      if (!out_free && !skid_valid_ff) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - $bits(result_type)){1'b0}}, out_data_ff};

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held while result register empty");

   a_tagged_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_TAGGED |-> count_ff >= CountWidth'(TagBytes))
      else $error("tagged packet shorter than its tag");

   a_kind_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_HUNT) == (kind_ff == KIND_UNKNOWN))
      else $error("packet kind out of step with framing phase");

   a_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_data_ff.length != '0)
      else $error("empty packet reported");

endmodule

FILE: dv/tb_tagged_packet_deframer.sv
module tb_tagged_packet_deframer;
   import tpd_pkg::*;

   localparam int StallLimit   = 2000;
   localparam int HoldCycles   = 400;
   localparam int RandomPhases = 8;
   localparam int PhaseBytes   = 190;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata = '0;   // [7:0] rx_byte
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // [2:0] packet_kind, [15:3] packet_length, [17:16] packet_status, [23:18] zero
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0]             csr_pwdata = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   tagged_packet_deframer u_dut (.*);

   // framing state and register copies
   logic [31:0] tag_reg [4];
   logic [31:0] data_tail;
   logic [15:0] button_tail;
   logic [12:0] data_length;
   logic [31:0] window;
   phase_type   phase;
   kind_type    open_kind;
   int          pkt_bytes;

   result_type  expected_packets [$];
   logic [7:0]  byte_queue [$];

   int errors = 0;
   int bytes_queued = 0;
   int bytes_taken = 0;
   int packets_seen = 0;
   int overflow_seen = 0;
   int len_err_seen = 0;
   int settings_used = 0;
   int quiet_cycles = 0;
   logic req_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int mode_left = 0;
   int ready_mode = 0;
   bit hold_go = 1'b0;
   bit hold_done = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      errors++;
   endtask

   function automatic kind_type tag_kind(input logic [31:0] w);
      kind_type k;
      k = KIND_UNKNOWN;
      // walk backward so the first register in order wins
      for (int i = 3; i >= 0; i--) if (w == tag_reg[i]) k = kind_type'(i);
      return k;
   endfunction

   function automatic void hunt_afresh();
      window = '0;
      phase = PHASE_HUNT;
      open_kind = KIND_UNKNOWN;
      pkt_bytes = 0;
   endfunction

   function automatic void queue_packet(input kind_type k, input int len, input status_type st);
      result_type r;
      r.kind = k;
      r.length = LengthWidth'(len);
      r.status = st;
      expected_packets.push_back(r);
   endfunction

   function automatic void frame_byte(input logic [7:0] b);
      kind_type   k;
      logic       done;
      status_type st;
      window = {b, window[31:8]};
      if (pkt_bytes < MaxPacketBytes) pkt_bytes++;
      if (phase == PHASE_HUNT) begin
         k = (pkt_bytes >= TagBytes) ? tag_kind(window) : KIND_UNKNOWN;
         if (k != KIND_UNKNOWN) begin
            // close whatever came ahead of the tag as an unknown packet
            if (pkt_bytes > TagBytes)
               queue_packet(KIND_UNKNOWN, pkt_bytes - TagBytes, STATUS_OK);
            phase = PHASE_TAGGED;
            open_kind = k;
            pkt_bytes = TagBytes;
         end else if (pkt_bytes >= MaxPacketBytes) begin
            queue_packet(KIND_UNKNOWN, pkt_bytes, STATUS_OVERFLOW);
            hunt_afresh();
         end
      end else begin
         st = STATUS_OK;
         case (open_kind)
            KIND_COMMAND, KIND_LOG: done = (pkt_bytes > TagBytes) && (b == LineEnd);
            KIND_DATA: begin
               done = (pkt_bytes >= TagBytes + DataTailBytes) && (window == data_tail);
               if (done && pkt_bytes != data_length) st = STATUS_LEN_ERR;
            end
            KIND_BUTTON: begin
               done = (pkt_bytes >= TagBytes + ButtonTailBytes) && (window[31:16] == button_tail);
            end
            default: done = 1'b0;
         endcase
         if (done) begin
            queue_packet(open_kind, pkt_bytes, st);
            hunt_afresh();
         end else if (pkt_bytes >= MaxPacketBytes) begin
            queue_packet(open_kind, pkt_bytes, STATUS_OVERFLOW);
            hunt_afresh();
         end
      end
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      byte_queue.push_back(b);
      bytes_queued++;
   endfunction

   function automatic logic [7:0] rand_byte(input bit no_line_end);
      logic [7:0] b;
      b = 8'($urandom);
      while (no_line_end && b == LineEnd) b = 8'($urandom);
      return b;
   endfunction

   // send the low n bytes of w, least significant first
   function automatic void push_word(input logic [31:0] w, input int n);
      for (int i = 0; i < n; i++) push_byte(w[8*i +: 8]);
   endfunction

   function automatic void push_payload(input int n, input bit no_line_end);
      for (int i = 0; i < n; i++) push_byte(rand_byte(no_line_end));
   endfunction

   function automatic void push_packet(input kind_type k, input int n);
      push_word(tag_reg[k], TagBytes);
      push_payload(n, 1'b1);
      case (k)
         KIND_COMMAND, KIND_LOG: push_byte(LineEnd);
         KIND_DATA: push_word(data_tail, DataTailBytes);
         default: push_word({16'h0, button_tail}, ButtonTailBytes);
      endcase
   endfunction

   function automatic void random_traffic(input int n, input bit short_commands);
      int       stop;
      int       pick;
      int       len;
      kind_type k;
      stop = bytes_queued + n;
      while (bytes_queued < stop) begin
         pick = $urandom_range(0, 9);
         k = kind_type'($urandom_range(0, 3));
         len = $urandom_range(0, 16);
         if (short_commands) begin
            push_packet(KIND_COMMAND, $urandom_range(0, 1));
         end else if (pick <= 6) begin
            if (k == KIND_DATA && data_length <= 40 && $urandom_range(0, 1) == 1)
               len = data_length - 8;
            push_packet(k, len);
         end else if (pick == 7) begin
            push_payload($urandom_range(1, 8), 1'b0);
         end else if (pick == 8) begin
            // cut-off tag
            push_word(tag_reg[k], $urandom_range(1, 3));
         end else begin
            // tag with unfiltered payload
            push_word(tag_reg[k], TagBytes);
            push_payload(len, 1'b0);
         end
      end
   endfunction

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] masked;
      case (idx)
         REG_TAIL_BUTTON: masked = value & 32'h0000_FFFF;
         REG_EXPECTED_LENGTH: masked = value & 32'h0000_1FFF;
         default: masked = value;
      endcase
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      // read back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== masked)
         report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, csr_prdata, masked));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_TAIL_DATA: data_tail = masked;
         REG_TAIL_BUTTON: button_tail = masked[15:0];
         REG_EXPECTED_LENGTH: data_length = masked[12:0];
         default: tag_reg[idx] = masked;
      endcase
   endtask

   task automatic random_settings(input int pick);
      logic [31:0] t [4];
      logic [31:0] v;
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = (i > 0) ? t[$urandom_range(0, i - 1)] : 32'($urandom);
            default: v = $urandom;
         endcase
         t[i] = v;
         write_reg(reg_index_type'(i), v);
      end
      case ($urandom_range(0, 3))
         0: v = '0;
         1: v = '1;
         default: v = $urandom;
      endcase
      write_reg(REG_TAIL_DATA, v);
      case ($urandom_range(0, 3))
         0: v = '0;
         1: v = '1;
         default: v = $urandom;
      endcase
      write_reg(REG_TAIL_BUTTON, v);
      case (pick % 3)
         0: v = 8;
         1: v = $urandom_range(9, 40);
         default: v = MaxPacketBytes;
      endcase
      write_reg(REG_EXPECTED_LENGTH, v);
      settings_used++;
   endtask

   // hold until every byte is in and every packet is out
   task automatic drain();
      while (bytes_taken != bytes_queued || expected_packets.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (gap_left > 0 || byte_queue.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= byte_queue.pop_front();
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HoldCycles;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= mode_left[2];
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            frame_byte(req_tdata);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            if (expected_packets.size() == 0) begin
               report_mismatch($sformatf("unexpected word kind %0d length %0d status %0d",
                                         got.kind, got.length, got.status));
            end else begin
               want = expected_packets.pop_front();
               if (got.kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
               if (got.length !== want.length)
                  report_mismatch($sformatf("length %0d, want %0d", got.length, want.length));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
               packets_seen++;
               if (want.status == STATUS_OVERFLOW) overflow_seen++;
               if (want.status == STATUS_LEN_ERR) len_err_seen++;
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < StallLimit) @(posedge clock);
      $display("no handshake for %0d cycles, giving up", StallLimit);
      $display("tagged_packet_deframer: mismatch");
      $finish;
   end

   initial begin
      tag_reg = '{32'h5F4D_4F43, 32'h0, 32'h0, 32'h0};
      data_tail = 32'h5A5A_5A5A;
      button_tail = 16'h5A5A;
      data_length = 13'd64;
      hunt_afresh();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: data, button and log tags are all zero, so data wins
      push_packet(KIND_COMMAND, 0);
      push_packet(KIND_DATA, 0);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_packet(KIND_COMMAND, 0);
      drain();

      write_reg(REG_TAG_DATA, 32'h5F54_4144);
      write_reg(REG_TAG_BUTTON, 32'h5F4E_5442);
      write_reg(REG_TAG_LOG, 32'h5F47_4F4C);
      // tail equal to the tag must not close the packet inside its own tag
      write_reg(REG_TAIL_DATA, 32'h5F54_4144);
      write_reg(REG_TAIL_BUTTON, 32'hFFFF_5A5A);
      write_reg(REG_EXPECTED_LENGTH, 32'd8);
      settings_used++;
      push_packet(KIND_DATA, 0);
      push_packet(KIND_BUTTON, 0);
      push_packet(KIND_LOG, 0);
      drain();

      for (int p = 0; p < RandomPhases; p++) begin
         random_settings(p);
         // starve the result side while short packets keep coming
         if (p == 2) hold_go = 1'b1;
         random_traffic(PhaseBytes, p == 2);
         drain();
      end

      random_settings(RandomPhases);
      random_traffic(PhaseBytes, 1'b0);
      drain();

      $display("covered %0d bytes and %0d packets over %0d register settings",
               bytes_taken, packets_seen, settings_used);
      $display("  %0d overflowed packets, %0d data length errors, one long result stall",
               overflow_seen, len_err_seen);
      if (errors == 0)
         $display("tagged_packet_deframer: match");
      else
         $display("tagged_packet_deframer: mismatch");
      $finish;
   end

endmodule
